### src/olst_pkg.sv
// ============================================================================
// olst_pkg: shared types for the ordered list engine
// Operation and status codes, FSM states and the structs broadcast to and passed
// along the chain of entry cells.
// ============================================================================
package olst_pkg;

	typedef enum logic [2:0] {
		MODE_READ   = 3'd0,
		MODE_SEARCH = 3'd1,
		MODE_APPEND = 3'd2,
		MODE_INSERT = 3'd3,
		MODE_DELETE = 3'd4,
		MODE_CLEAR  = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_POS   = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} state_t;

	localparam int unsigned POS_W   = 5;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned FPOS_W  = 4;
	localparam int unsigned CAP_W   = 5;

	// Operation broadcast to every cell.
	typedef struct packed {
		mode_t               mode;
		logic [POS_W-1:0]    position;
		logic [VALUE_W-1:0]  value;
		logic                do_append;
		logic                do_insert;
		logic                do_delete;
	} cell_ctrl_t;

	// Scan token handed from cell to cell, one cell per cycle.
	typedef struct packed {
		logic                hit;
		logic [VALUE_W-1:0]  data;
		logic [FPOS_W-1:0]   fpos;
	} token_t;

endpackage

### src/ordered_list_engine_core.sv
// ============================================================================
// ordered_list_engine_core: ordered list of signed 32-bit entries
// A chain of entry cells with an operation controller and a result register.
// ============================================================================
// Read, search and delete pass through the scan state before the apply state;
// append, insert, clear and unused modes go to apply directly. Apply waits
// while an earlier result is not yet taken. A new item is taken only after the
// previous one is applied; the token crosses one cell of the chain per cycle.
// Reset: list length 0 and capacity 16; entries are not cleared.
module ordered_list_engine_core #(
	parameter int unsigned DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input beats. s_tdata fields from bit 0 up: mode[2:0], position[4:0],
	// value[31:0].
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	// Result beats. m_tdata fields from bit 0 up: status[1:0], data_out[31:0],
	// found_position[3:0], entry_count[4:0], is_empty, is_full, zero fill.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,
	// Capacity register write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);

	// Cell index width and length width; the length must be able to hold DEPTH.
	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned LW = $clog2(DEPTH + 1);
	localparam int unsigned CW = (LW > olst_pkg::CAP_W) ? LW : olst_pkg::CAP_W;

	olst_pkg::state_t                 state_q, state_nx;
	logic [IW-1:0]                    cnt_q;
	olst_pkg::mode_t                  op_mode_q;
	logic [olst_pkg::POS_W-1:0]       op_pos_q;
	logic [31:0]                      op_val_q;
	logic [LW-1:0]                    len_q, len_nx;
	logic [olst_pkg::CAP_W-1:0]       cap_q;

	logic                             out_valid_q;
	logic [47:0]                      out_data_q;

	logic                             in_go;
	logic                             apply_go;
	logic                             needs_scan;
	olst_pkg::mode_t                  in_mode;
	olst_pkg::cell_ctrl_t             ctrl;
	olst_pkg::status_t                status;
	logic [31:0]                      data_out;
	logic [olst_pkg::FPOS_W-1:0]      fpos;
	logic [CW-1:0]                    cap_c, len_c, pos_c;
	logic                             full_now;

	logic [31:0]                      entry_w [DEPTH];
	olst_pkg::token_t                 tok_w   [DEPTH+1];

	// ------------------------------------------------------------------
	// Handshakes. A new item is taken only when the controller is idle; the
	// result register lets it start while the previous result still waits.
	// ------------------------------------------------------------------
	assign s_tready  = (state_q == olst_pkg::ST_IDLE);
	assign in_go     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign apply_go  = (state_q == olst_pkg::ST_APPLY) && (!out_valid_q || m_tready);
	assign in_mode   = olst_pkg::mode_t'(s_tdata[2:0]);

	// Read, search and delete need the token to sweep the whole chain.
	assign needs_scan = (in_mode == olst_pkg::MODE_READ) ||
	                    (in_mode == olst_pkg::MODE_SEARCH) ||
	                    (in_mode == olst_pkg::MODE_DELETE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= olst_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			olst_pkg::ST_IDLE: begin
				if (in_go) begin
					state_nx = needs_scan ? olst_pkg::ST_SCAN : olst_pkg::ST_APPLY;
				end
			end
			olst_pkg::ST_SCAN: begin
				if (cnt_q == IW'(DEPTH - 1)) begin
					state_nx = olst_pkg::ST_APPLY;
				end
			end
			olst_pkg::ST_APPLY: begin
				if (apply_go) begin
					state_nx = olst_pkg::ST_IDLE;
				end
			end
			default: state_nx = olst_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_go) begin
			cnt_q <= '0;
		end else if (state_q == olst_pkg::ST_SCAN) begin
			cnt_q <= cnt_q + IW'(1);
		end
	end

	// Operation registers hold still for the whole scan.
	always_ff @(posedge clk) begin
		if (in_go) begin
			op_mode_q <= in_mode;
			op_pos_q  <= s_tdata[7:3];
			op_val_q  <= s_tdata[39:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= olst_pkg::CAP_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// ------------------------------------------------------------------
	// Decision in the apply cycle. The token leaving the last cell carries the
	// addressed entry and the first search hit, taken before any shift.
	// ------------------------------------------------------------------
	assign cap_c    = (CW'(cap_q) < CW'(DEPTH)) ? CW'(cap_q) : CW'(DEPTH);
	assign len_c    = CW'(len_q);
	assign pos_c    = CW'(op_pos_q);
	assign full_now = (len_c >= cap_c);

	always_comb begin
		status         = olst_pkg::STAT_OK;
		data_out       = '0;
		fpos           = '0;
		len_nx         = len_q;
		ctrl.mode      = op_mode_q;
		ctrl.position  = op_pos_q;
		ctrl.value     = op_val_q;
		ctrl.do_append = 1'b0;
		ctrl.do_insert = 1'b0;
		ctrl.do_delete = 1'b0;
		case (op_mode_q)
			olst_pkg::MODE_READ: begin
				if (pos_c < len_c) begin
					data_out = tok_w[DEPTH].data;
				end else begin
					status = olst_pkg::STAT_BAD_POS;
				end
			end
			olst_pkg::MODE_SEARCH: begin
				if (tok_w[DEPTH].hit) begin
					fpos = tok_w[DEPTH].fpos;
				end else begin
					status = olst_pkg::STAT_NOT_FOUND;
				end
			end
			olst_pkg::MODE_APPEND: begin
				if (full_now) begin
					status = olst_pkg::STAT_FULL;
				end else begin
					ctrl.do_append = apply_go;
					len_nx         = len_q + LW'(1);
				end
			end
			olst_pkg::MODE_INSERT: begin
				if (pos_c > len_c) begin
					status = olst_pkg::STAT_BAD_POS;
				end else if (full_now) begin
					status = olst_pkg::STAT_FULL;
				end else begin
					ctrl.do_insert = apply_go;
					len_nx         = len_q + LW'(1);
				end
			end
			olst_pkg::MODE_DELETE: begin
				if (pos_c < len_c) begin
					data_out       = tok_w[DEPTH].data;
					ctrl.do_delete = apply_go;
					len_nx         = len_q - LW'(1);
				end else begin
					status = olst_pkg::STAT_BAD_POS;
				end
			end
			olst_pkg::MODE_CLEAR: begin
				len_nx = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (apply_go) begin
			len_q <= len_nx;
		end
	end

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			out_data_q <= {3'b000,
			               (CW'(len_nx) >= cap_c),
			               (len_nx == '0),
			               olst_pkg::CAP_W'(len_nx),
			               fpos,
			               data_out,
			               status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// ------------------------------------------------------------------
	// Chain of entry cells. Cell 0 receives an empty token every cycle.
	// ------------------------------------------------------------------
	assign tok_w[0] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [31:0] left_w;
		logic [31:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = entry_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = entry_w[i+1];
		end

		olst_cell #(
			.IW (IW),
			.LW (LW)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.length      (len_q),
			.index       (IW'(i)),
			.left_entry  (left_w),
			.right_entry (right_w),
			.entry       (entry_w[i]),
			.tok_in      (tok_w[i]),
			.tok_out     (tok_w[i+1])
		);
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(len_q) <= CW'(DEPTH))
		else $error("list length exceeds DEPTH");

	a_apply_shows: assert property (@(posedge clk) disable iff (!arst_n)
		apply_go |=> m_tvalid)
		else $error("applied item produced no result beat");

	a_len_only_apply: assert property (@(posedge clk) disable iff (!arst_n)
		!apply_go |=> $stable(len_q))
		else $error("length changed outside the apply cycle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_go |=> !s_tready)
		else $error("input ready while an item is in flight");

	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == olst_pkg::ST_SCAN && cnt_q == IW'(DEPTH - 1))
			|=> state_q == olst_pkg::ST_APPLY)
		else $error("scan did not end after DEPTH cycles");

endmodule

### src/olst_cell.sv
// ============================================================================
// olst_cell: one entry cell of the list chain
// Holds one entry, writes it on append, shifts it with its neighbors on insert
// and delete, and updates the passing scan token for read, delete and search.
// ============================================================================
module olst_cell #(
	parameter int unsigned IW = 4,
	parameter int unsigned LW = 5
) (
	input  logic                   clk,
	input  olst_pkg::cell_ctrl_t   ctrl,
	input  logic [LW-1:0]          length,
	input  logic [IW-1:0]          index,
	input  logic [31:0]            left_entry,
	input  logic [31:0]            right_entry,
	output logic [31:0]            entry,
	input  olst_pkg::token_t       tok_in,
	output olst_pkg::token_t       tok_out
);

	localparam int unsigned CW = (LW > olst_pkg::POS_W) ? LW : olst_pkg::POS_W;

	logic [CW-1:0]      idx_c;
	logic [CW-1:0]      pos_c;
	logic [CW-1:0]      len_c;
	logic [31:0]        entry_q;
	olst_pkg::token_t   tok_q;
	olst_pkg::token_t   tok_nx;

	assign idx_c = CW'(index);
	assign pos_c = CW'(ctrl.position);
	assign len_c = CW'(length);

	always_comb begin
		tok_nx = tok_in;
		if ((ctrl.mode == olst_pkg::MODE_READ || ctrl.mode == olst_pkg::MODE_DELETE)
				&& idx_c == pos_c) begin
			tok_nx.data = entry_q;
		end
		if (ctrl.mode == olst_pkg::MODE_SEARCH && !tok_in.hit && idx_c < len_c
				&& entry_q == ctrl.value) begin
			tok_nx.hit  = 1'b1;
			tok_nx.fpos = olst_pkg::FPOS_W'(index);
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nx;
	end

	// Insert moves entries up from the left, delete pulls them down from the right.
	always_ff @(posedge clk) begin
		if (ctrl.do_append && idx_c == len_c) begin
			entry_q <= ctrl.value;
		end else if (ctrl.do_insert && idx_c == pos_c) begin
			entry_q <= ctrl.value;
		end else if (ctrl.do_insert && idx_c > pos_c && idx_c <= len_c) begin
			entry_q <= left_entry;
		end else if (ctrl.do_delete && idx_c >= pos_c && (idx_c + CW'(1)) < len_c) begin
			entry_q <= right_entry;
		end
	end

	assign entry   = entry_q;
	assign tok_out = tok_q;

endmodule
